[hw/rtl/easf_pkg.sv]
// shared types and constants for the encoder angle and speed filter
`timescale 1ns / 1ps
`default_nettype none
package easf_pkg;

  localparam int ANGLE_BITS    = 14;
  localparam int FRACTION_BITS = 16;
  localparam int TURN_BITS     = ANGLE_BITS + FRACTION_BITS;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_SPEED  = 2'd1;
  localparam logic [1:0] ACT_TURNS  = 2'd2;

  localparam int RegAddrBits = 5;
  localparam logic [2:0] REG_MAX_ANGLE_JUMP    = 3'd0;
  localparam logic [2:0] REG_SPIKE_RUN_LIMIT   = 3'd1;
  localparam logic [2:0] REG_ANGLE_ALPHA       = 3'd2;
  localparam logic [2:0] REG_RPM_ALPHA         = 3'd3;
  localparam logic [2:0] REG_SPEED_STEP_LIMIT  = 3'd4;
  localparam logic [2:0] REG_TURNS_ALPHA       = 3'd5;

  // microseconds per minute in Q.8 rpm, divided by 2^16
  localparam logic [17:0] MIN_PER_US_Q8 = 18'd234375;
  localparam logic [31:0] SLOW_LIMIT = 32'd25;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] raw_word;
    logic [23:0] interval_us;
  } in_word_t;

  typedef struct packed {
    logic [29:0] angle;
    logic [31:0] speed_rpm;
    logic [47:0] turn_angle;
    logic        held;
  } out_word_t;

  typedef struct packed {
    logic [13:0] max_angle_jump;
    logic [7:0]  spike_run_limit;
    logic [16:0] angle_alpha;
    logic [16:0] rpm_alpha;
    logic [30:0] speed_step_limit;
    logic [16:0] turns_alpha;
  } cfg_regs_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture input word
    logic step;      // advance one datapath phase
    logic div_step;  // one quotient bit
    logic finish;    // commit result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] action;
  } dp_sts_t;

endpackage
`default_nettype wire

[hw/rtl/easf_ctrl.sv]
// controller sequencing the filter datapath
`timescale 1ns / 1ps
`default_nettype none
module easf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output easf_pkg::dp_cmd_t      cmd,
  input  wire easf_pkg::dp_sts_t sts
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRE  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_POST = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PRE;
          cnt_nxt   = '0;
        end
      end
      ST_PRE: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = (sts.action == easf_pkg::ACT_SPEED) ? ST_DIV : ST_POST;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          cnt_nxt   = '0;
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        // phases 3 to 7
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd4) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.finish = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/easf_datapath.sv]
// filter state, serial divider and iir arithmetic
`timescale 1ns / 1ps
`default_nettype none
module easf_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire easf_pkg::in_word_t  in_word,
  input  wire easf_pkg::cfg_regs_t cfg,
  input  wire easf_pkg::dp_cmd_t   cmd,
  output easf_pkg::dp_sts_t        sts,
  output easf_pkg::out_word_t      out_word
);
  localparam int ANGLE_BITS    = easf_pkg::ANGLE_BITS;
  localparam int FRACTION_BITS = easf_pkg::FRACTION_BITS;
  localparam int TB = easf_pkg::TURN_BITS;
  localparam int DW = TB + 1;
  localparam int DEN_SH = TB - 16;

  easf_pkg::in_word_t in_r;
  logic [2:0]  ph_r;
  logic [ANGLE_BITS-1:0] last_raw_r;
  logic [7:0]  spike_r;
  logic [TB-1:0] fang_r, sprev_r, tprev_r;
  logic signed [31:0] prev_spd_r, fspd_r;
  logic [31:0] tcount_r;
  logic signed [47:0] fturn_r;
  logic        held_r;
  // general working registers
  logic signed [DW:0]  d_r;     // wrapped difference
  logic signed [49:0]  w_r;     // filter difference
  logic [16:0]         alpha_r;
  logic [65:0]         prod_r;
  logic                go_r;
  // divider
  logic [31:0] q_r;
  logic [55:0] rem_r;
  logic [55:0] num_r;
  logic [55:0] den_r;
  logic signed [32:0] inst_r;
  logic signed [47:0] tgt_r;

  assign sts.action = in_r.action;

  // rounding weighted step, half away from zero
  function automatic logic signed [49:0] wround(input logic signed [49:0] d,
                                                input logic [65:0] p,
                                                input logic [16:0] a);
    logic [49:0] s;
    begin
      s = 50'((p + 66'd32768) >> 16);
      if (a[16]) wround = d;
      else wround = d[49] ? -$signed(s) : $signed(s);
    end
  endfunction

  logic [ANGLE_BITS-1:0] raw;
  logic [ANGLE_BITS-1:0] rd;
  logic [ANGLE_BITS-1:0] rmag;
  logic signed [49:0] step_v;
  logic [49:0] wmag;
  logic [55:0] trial;
  logic signed [33:0] delta;
  logic [33:0] dmag;
  logic [33:0] lim;
  logic signed [33:0] fnew;
  logic [31:0] fmag;
  logic signed [TB:0] tdiff;
  logic signed [32:0] tc_s;
  logic signed [49:0] out_t;

  always_comb begin
    raw   = in_r.raw_word[ANGLE_BITS+1:2];
    rd    = raw - last_raw_r;
    rmag  = rd[ANGLE_BITS-1] ? -rd : rd;
    wmag  = w_r[49] ? 50'(-w_r) : 50'(w_r);
    step_v = wround(w_r, prod_r, alpha_r);
    trial = {rem_r[54:0], num_r[55]};
    delta = 34'(inst_r) - 34'(prev_spd_r);
    dmag  = delta[33] ? -delta : delta;
    lim   = (dmag >> 1) > 34'(cfg.speed_step_limit) ? 34'(cfg.speed_step_limit)
                                                    : (dmag >> 1);
    fnew  = 34'(fspd_r) + 34'(step_v);
    if (fnew > 34'sd2147483647) fnew = 34'sd2147483647;
    if (fnew < -34'sd2147483648) fnew = -34'sd2147483648;
    fmag  = fnew[33] ? 32'(-fnew) : 32'(fnew);
    tdiff = $signed({1'b0, fang_r}) - $signed({1'b0, tprev_r});
    tc_s  = $signed({tcount_r[31], tcount_r});
    out_t = 50'(tc_s) * 50'(51'd1 << TB) + 50'($signed({1'b0, fang_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= '0; spike_r <= '0; fang_r <= '0; sprev_r <= '0;
      tprev_r <= '0; prev_spd_r <= '0; fspd_r <= '0; tcount_r <= '0;
      fturn_r <= '0; ph_r <= '0; held_r <= 1'b0; go_r <= 1'b0;
    end else if (cmd.load) begin
      in_r   <= in_word;
      ph_r   <= '0;
      held_r <= 1'b0;
      go_r   <= 1'b0;
    end else if (cmd.div_step) begin
      num_r <= num_r << 1;
      if (trial >= den_r) begin
        rem_r <= trial - den_r;
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[30:0], 1'b0};
      end
    end else if (cmd.step) begin
      ph_r <= ph_r + 3'd1;
      unique case (in_r.action)
        easf_pkg::ACT_SAMPLE: begin
          if (ph_r == 3'd0) begin
            if (32'(rmag) > 32'(cfg.max_angle_jump) &&
                (9'(spike_r) + 9'd1) < 9'(cfg.spike_run_limit)) begin
              spike_r <= spike_r + 8'd1;
              held_r  <= 1'b1;
              go_r    <= 1'b0;
            end else begin
              go_r    <= 1'b1;
            end
          end else if (ph_r == 3'd1) begin
            if (go_r) begin
              spike_r    <= '0;
              last_raw_r <= raw;
              w_r <= 50'($signed(TB'({raw, FRACTION_BITS'(0)} - fang_r)));
              alpha_r <= cfg.angle_alpha;
            end
          end else if (ph_r == 3'd2) begin
            prod_r <= 66'(wmag) * 66'(alpha_r);
          end else if (ph_r == 3'd3) begin
            if (go_r) fang_r <= TB'(50'(fang_r) + step_v);
          end
        end
        easf_pkg::ACT_SPEED: begin
          if (ph_r == 3'd0) begin
            d_r <= (DW+1)'($signed(TB'(fang_r - sprev_r)));
            sprev_r <= fang_r;
            den_r <= 56'((in_r.interval_us == 24'd0) ? 24'd1 : in_r.interval_us) << DEN_SH;
          end else if (ph_r == 3'd1) begin
            prod_r <= 66'(d_r[DW] ? -d_r : d_r) * 66'(easf_pkg::MIN_PER_US_Q8);
          end else if (ph_r == 3'd2) begin
            // low 32 dividend bits are shifted in, the rest starts as remainder
            num_r <= prod_r[55:0] << 24;
            rem_r <= 56'(prod_r[55:32]);
            q_r   <= '0;
          end else if (ph_r == 3'd3) begin
            // upper dividend part not below the divisor means the quotient overflows
            if (56'(prod_r[65:32]) >= den_r || q_r[31])
              inst_r <= d_r[DW] ? -33'sd2147483648 : 33'sd2147483647;
            else
              inst_r <= d_r[DW] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
          end else if (ph_r == 3'd4) begin
            if (dmag > 34'(cfg.speed_step_limit))
              inst_r <= 33'(delta[33] ? 34'(prev_spd_r) - lim : 34'(prev_spd_r) + lim);
          end else if (ph_r == 3'd5) begin
            w_r <= 50'(inst_r) - 50'(fspd_r);
            alpha_r <= cfg.rpm_alpha;
          end else if (ph_r == 3'd6) begin
            prod_r <= 66'(wmag) * 66'(alpha_r);
          end else begin
            prev_spd_r <= 32'(inst_r);
            fspd_r <= (fmag <= easf_pkg::SLOW_LIMIT) ? '0 : 32'(fnew);
          end
        end
        easf_pkg::ACT_TURNS: begin
          if (ph_r == 3'd0) begin
            if (tdiff < -$signed((TB+1)'(1) << (TB-1))) tcount_r <= tcount_r + 32'd1;
            else if (tdiff > $signed((TB+1)'(1) << (TB-1))) tcount_r <= tcount_r - 32'd1;
          end else if (ph_r == 3'd1) begin
            if (tc_s > (33'sd1 <<< (47 - TB)))
              tgt_r <= 48'sh7FFFFFFFFFFF;
            else if (tc_s < -(33'sd1 <<< (47 - TB)))
              tgt_r <= 48'sh800000000000;
            else if (out_t > 50'sh7FFFFFFFFFFF)
              tgt_r <= 48'sh7FFFFFFFFFFF;
            else if (out_t < -50'sh800000000000)
              tgt_r <= 48'sh800000000000;
            else tgt_r <= 48'(out_t);
          end else if (ph_r == 3'd2) begin
            w_r <= 50'(tgt_r) - 50'(fturn_r);
            alpha_r <= cfg.turns_alpha;
            tprev_r <= fang_r;
          end else if (ph_r == 3'd3) begin
            prod_r <= 66'(wmag) * 66'(alpha_r);
          end else if (ph_r == 3'd4) begin
            fturn_r <= 48'(50'(fturn_r) + step_v);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_word.angle      = 30'(fang_r);
  assign out_word.speed_rpm  = fspd_r;
  assign out_word.turn_angle = fturn_r;
  assign out_word.held       = held_r;
endmodule
`default_nettype wire

[hw/rtl/easf_cfg.sv]
// apb configuration register file
`timescale 1ns / 1ps
`default_nettype none
module easf_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [easf_pkg::RegAddrBits-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output easf_pkg::cfg_regs_t      cfg
);
  easf_pkg::cfg_regs_t cfg_r;
  logic [2:0] idx;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_angle_jump   <= 14'd512;
      cfg_r.spike_run_limit  <= 8'd3;
      cfg_r.angle_alpha      <= 17'd16384;
      cfg_r.rpm_alpha        <= 17'd6554;
      cfg_r.speed_step_limit <= 31'd256000;
      cfg_r.turns_alpha      <= 17'd32768;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        easf_pkg::REG_MAX_ANGLE_JUMP:   cfg_r.max_angle_jump <= pwdata[13:0];
        easf_pkg::REG_SPIKE_RUN_LIMIT:  cfg_r.spike_run_limit <= pwdata[7:0];
        easf_pkg::REG_ANGLE_ALPHA:      cfg_r.angle_alpha <= pwdata[16:0];
        easf_pkg::REG_RPM_ALPHA:        cfg_r.rpm_alpha <= pwdata[16:0];
        easf_pkg::REG_SPEED_STEP_LIMIT: cfg_r.speed_step_limit <= pwdata[30:0];
        easf_pkg::REG_TURNS_ALPHA:      cfg_r.turns_alpha <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      easf_pkg::REG_MAX_ANGLE_JUMP:   prdata = 32'(cfg_r.max_angle_jump);
      easf_pkg::REG_SPIKE_RUN_LIMIT:  prdata = 32'(cfg_r.spike_run_limit);
      easf_pkg::REG_ANGLE_ALPHA:      prdata = 32'(cfg_r.angle_alpha);
      easf_pkg::REG_RPM_ALPHA:        prdata = 32'(cfg_r.rpm_alpha);
      easf_pkg::REG_SPEED_STEP_LIMIT: prdata = 32'(cfg_r.speed_step_limit);
      easf_pkg::REG_TURNS_ALPHA:      prdata = 32'(cfg_r.turns_alpha);
      default:                        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

[hw/rtl/encoder_angle_speed_filter.sv]
// Encoder angle and speed filter, top level.
// Input words carry an action: 0 takes an encoder sample (spike rejection and
// angle iir), 1 computes speed in Q.8 rpm over interval_us, 2 updates the
// multi-turn angle. Every accepted word yields exactly one output word that
// shows all filter outputs, with held set when a sample was rejected.
// Samples, turn updates and unused actions pass 3 setup phases, 5 finishing
// phases and a commit between the accepting edge and out_valid; a speed
// update also runs a restoring divider between the setup and finishing
// phases that produces one quotient bit a cycle.
// One word is in flight at a time; in_ready is high only while idle, so a
// new word is not accepted until the last one has been committed.
// The output register keeps a finished word while the receiver stalls, and
// the next word can be accepted meanwhile; its result waits until the held
// word is taken.
// Reset clears all filter state and loads the register defaults.
// Configuration goes through the apb-style port, registers at 4*index.
`timescale 1ns / 1ps
`default_nettype none
module encoder_angle_speed_filter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire easf_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output easf_pkg::out_word_t       out_data,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [easf_pkg::RegAddrBits-1:0] cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  easf_pkg::cfg_regs_t cfg;
  easf_pkg::dp_cmd_t   cmd;
  easf_pkg::dp_sts_t   sts;
  easf_pkg::out_word_t res;
  easf_pkg::out_word_t out_r;

  assign cfg_pready = 1'b1;

  easf_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .cfg(cfg)
  );

  easf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  easf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_data), .cfg(cfg), .cmd(cmd),
    .sts(sts), .out_word(res)
  );

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= res;
  end
  assign out_data = out_r;
endmodule
`default_nettype wire

[sim/encoder_angle_speed_filter_test.sv]
// self-checking testbench for the encoder angle and speed filter
`timescale 1ns / 1ps
module encoder_angle_speed_filter_test;

  localparam int TURN_BITS = 30;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  easf_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  easf_pkg::out_word_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [easf_pkg::RegAddrBits-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  encoder_angle_speed_filter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // filter settings mirrored from the register writes
  logic [13:0] jump_limit;
  logic [7:0]  spike_limit;
  logic [16:0] angle_weight, speed_weight, turns_weight;
  logic [30:0] speed_jump_limit;

  // filter state
  logic [13:0] last_raw;
  logic [7:0]  spike_cnt;
  logic [29:0] angle_f, speed_ref_angle, turns_ref_angle;
  longint      speed_prev, speed_f, turn_angle_f;
  logic [31:0] turn_cnt;

  easf_pkg::out_word_t expected_words[$];
  int  errors = 0;
  int  words_sent = 0, words_checked = 0, speed_words = 0;
  longint cycles = 0;

  function automatic longint abs64(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint wrap_to(longint x, int bits);
    longint full, r;
    full = longint'(1) << bits;
    r = x & (full - 1);
    return r >= (full >> 1) ? r - full : r;
  endfunction

  function automatic longint iir_step(longint d, logic [16:0] alpha);
    longint unsigned m, s;
    if (alpha >= 17'd65536) return d;
    m = abs64(d);
    s = (m * 64'(alpha) + 64'd32768) >> 16;
    return d < 0 ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  task automatic predict_filter(input easf_pkg::in_word_t w, output easf_pkg::out_word_t r);
    longint d, q, inst, delta, lim, f, tc, tgt, half, top, qmax;
    logic [13:0] raw;
    logic [23:0] dt;
    logic held;
    held = 1'b0;
    case (w.action)
      easf_pkg::ACT_SAMPLE: begin
        raw = w.raw_word[15:2];
        d = wrap_to(longint'(raw) - longint'(last_raw), 14);
        if (abs64(d) > longint'(jump_limit) && (spike_cnt + 9'd1) < spike_limit) begin
          spike_cnt = spike_cnt + 8'd1;
          held = 1'b1;
        end else begin
          spike_cnt = '0;
          last_raw = raw;
          d = wrap_to((longint'(raw) << 16) - longint'(angle_f), TURN_BITS);
          angle_f = 30'(longint'(angle_f) + iir_step(d, angle_weight));
        end
      end
      easf_pkg::ACT_SPEED: begin
        d = wrap_to(longint'(angle_f) - longint'(speed_ref_angle), TURN_BITS);
        speed_ref_angle = angle_f;
        dt = (w.interval_us == 0) ? 24'd1 : w.interval_us;
        q = (abs64(d) * 234375) / (longint'(dt) << (TURN_BITS - 16));
        if (q > (longint'(1) << 31)) q = longint'(1) << 31;
        inst = clamp32(d < 0 ? -q : q);
        delta = inst - speed_prev;
        if (abs64(delta) > longint'(speed_jump_limit)) begin
          lim = abs64(delta) >>> 1;
          if (lim > longint'(speed_jump_limit)) lim = longint'(speed_jump_limit);
          inst = delta < 0 ? speed_prev - lim : speed_prev + lim;
        end
        f = clamp32(speed_f + iir_step(inst - speed_f, speed_weight));
        if (abs64(f) <= 25) f = 0;
        speed_prev = inst;
        speed_f = f;
      end
      easf_pkg::ACT_TURNS: begin
        half = longint'(1) << (TURN_BITS - 1);
        top = longint'(1) << 47;
        qmax = top >>> TURN_BITS;
        d = longint'(angle_f) - longint'(turns_ref_angle);
        if (d < -half) turn_cnt = turn_cnt + 1;
        else if (d > half) turn_cnt = turn_cnt - 1;
        tc = longint'($signed(turn_cnt));
        if (tc > qmax) tgt = top - 1;
        else if (tc < -qmax) tgt = -top;
        else begin
          tgt = tc * (longint'(1) << TURN_BITS) + longint'(angle_f);
          if (tgt > top - 1) tgt = top - 1;
          if (tgt < -top) tgt = -top;
        end
        turn_angle_f = turn_angle_f + iir_step(tgt - turn_angle_f, turns_weight);
        turns_ref_angle = angle_f;
      end
      default: ;
    endcase
    r.angle = angle_f;
    r.speed_rpm = 32'(speed_f);
    r.turn_angle = 48'(turn_angle_f);
    r.held = held;
  endtask

  task automatic reset_model();
    jump_limit = 14'd512; spike_limit = 8'd3; angle_weight = 17'd16384;
    speed_weight = 17'd6554; speed_jump_limit = 31'd256000; turns_weight = 17'd32768;
    last_raw = '0; spike_cnt = '0; angle_f = '0; speed_ref_angle = '0;
    turns_ref_angle = '0; speed_prev = 0; speed_f = 0; turn_angle_f = 0; turn_cnt = '0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= easf_pkg::RegAddrBits'({idx, 2'b00}); cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      easf_pkg::REG_MAX_ANGLE_JUMP:   jump_limit = value[13:0];
      easf_pkg::REG_SPIKE_RUN_LIMIT:  spike_limit = value[7:0];
      easf_pkg::REG_ANGLE_ALPHA:      angle_weight = value[16:0];
      easf_pkg::REG_RPM_ALPHA:        speed_weight = value[16:0];
      easf_pkg::REG_SPEED_STEP_LIMIT: speed_jump_limit = value[30:0];
      easf_pkg::REG_TURNS_ALPHA:      turns_weight = value[16:0];
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // drive one word; a pinned row is checked against its typed-in result
  task automatic send_word(input easf_pkg::in_word_t w, input logic pinned,
                           input easf_pkg::out_word_t pin, input logic allow_gap);
    easf_pkg::out_word_t r;
    int gap;
    gap = allow_gap ? pick_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    predict_filter(w, r);
    expected_words.push_back(pinned ? pin : r);
    if (w.action == easf_pkg::ACT_SPEED) speed_words++;
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic easf_pkg::in_word_t make_word(logic [1:0] act, logic [15:0] raw,
                                                   logic [23:0] dt);
    easf_pkg::in_word_t w;
    w.action = act; w.raw_word = raw; w.interval_us = dt;
    return w;
  endfunction

  // receiver stalls
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    easf_pkg::out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word %h", out_data);
        errors++;
      end else begin
        e = expected_words.pop_front();
        words_checked++;
        if (out_data.angle !== e.angle) begin
          $error("angle expected %h got %h", e.angle, out_data.angle); errors++;
        end
        if (out_data.speed_rpm !== e.speed_rpm) begin
          $error("speed_rpm expected %h got %h", e.speed_rpm, out_data.speed_rpm); errors++;
        end
        if (out_data.turn_angle !== e.turn_angle) begin
          $error("turn_angle expected %h got %h", e.turn_angle, out_data.turn_angle);
          errors++;
        end
        if (out_data.held !== e.held) begin
          $error("held expected %b got %b", e.held, out_data.held); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  typedef struct {
    logic [1:0]  act;
    logic [15:0] raw;
    logic [23:0] dt;
    logic        pinned;
    easf_pkg::out_word_t result;
  } stim_row_t;

  stim_row_t directed_rows[$];

  initial begin
    easf_pkg::in_word_t w;
    easf_pkg::out_word_t none;
    logic [13:0] base;
    int phase, k, n, sel;
    none = '0;
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows; results typed in only where obvious
    directed_rows = '{
      '{easf_pkg::ACT_SAMPLE, 16'h0000, 24'd0, 1'b1, '{30'd0, 32'd0, 48'd0, 1'b0}},
      '{easf_pkg::ACT_SPEED,  16'h0000, 24'd0, 1'b1, '{30'd0, 32'd0, 48'd0, 1'b0}},
      '{easf_pkg::ACT_TURNS,  16'h0000, 24'd0, 1'b1, '{30'd0, 32'd0, 48'd0, 1'b0}},
      '{ACT_NONE,             16'hFFFF, 24'hFFFFFF, 1'b1, '{30'd0, 32'd0, 48'd0, 1'b0}},
      // big jump rejected twice, then accepted
      '{easf_pkg::ACT_SAMPLE, 16'h8000, 24'd0, 1'b1, '{30'd0, 32'd0, 48'd0, 1'b1}},
      '{easf_pkg::ACT_SAMPLE, 16'h8003, 24'd0, 1'b1, '{30'd0, 32'd0, 48'd0, 1'b1}},
      '{easf_pkg::ACT_SAMPLE, 16'h8000, 24'd0, 1'b0, none},
      '{easf_pkg::ACT_SAMPLE, 16'hFFFF, 24'd0, 1'b0, none},
      '{easf_pkg::ACT_SPEED,  16'h0000, 24'd1, 1'b0, none},
      '{easf_pkg::ACT_SAMPLE, 16'h0004, 24'd0, 1'b0, none},
      '{easf_pkg::ACT_SPEED,  16'hFFFF, 24'hFFFFFF, 1'b0, none},
      '{easf_pkg::ACT_TURNS,  16'h0000, 24'd0, 1'b0, none},
      '{easf_pkg::ACT_SAMPLE, 16'h7FFC, 24'd0, 1'b0, none},
      '{easf_pkg::ACT_SPEED,  16'h0000, 24'd100, 1'b0, none},
      '{easf_pkg::ACT_TURNS,  16'h0000, 24'd0, 1'b0, none},
      '{easf_pkg::ACT_SPEED,  16'h0000, 24'd50, 1'b0, none}
    };
    foreach (directed_rows[i]) begin
      w = make_word(directed_rows[i].act, directed_rows[i].raw, directed_rows[i].dt);
      send_word(w, directed_rows[i].pinned, directed_rows[i].result, 1'b0);
    end
    drain();

    // register settings per phase: extremes first, then the defaults, then random
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(easf_pkg::REG_MAX_ANGLE_JUMP, 32'd0);
          write_reg(easf_pkg::REG_SPIKE_RUN_LIMIT, 32'd0);
          write_reg(easf_pkg::REG_ANGLE_ALPHA, 32'd65536);
          write_reg(easf_pkg::REG_RPM_ALPHA, 32'd65536);
          write_reg(easf_pkg::REG_SPEED_STEP_LIMIT, 32'd0);
          write_reg(easf_pkg::REG_TURNS_ALPHA, 32'd65536);
        end
        1: begin
          write_reg(easf_pkg::REG_MAX_ANGLE_JUMP, 32'd8192);
          write_reg(easf_pkg::REG_SPIKE_RUN_LIMIT, 32'd255);
          write_reg(easf_pkg::REG_ANGLE_ALPHA, 32'd0);
          write_reg(easf_pkg::REG_RPM_ALPHA, 32'd0);
          write_reg(easf_pkg::REG_SPEED_STEP_LIMIT, 32'h7FFFFFFF);
          write_reg(easf_pkg::REG_TURNS_ALPHA, 32'd0);
        end
        2: begin
          write_reg(easf_pkg::REG_MAX_ANGLE_JUMP, 32'h3FFF);
          write_reg(easf_pkg::REG_SPIKE_RUN_LIMIT, 32'd1);
          write_reg(easf_pkg::REG_ANGLE_ALPHA, 32'h1FFFF);
          write_reg(easf_pkg::REG_RPM_ALPHA, 32'h1FFFF);
          write_reg(easf_pkg::REG_SPEED_STEP_LIMIT, 32'h7FFFFFFF);
          write_reg(easf_pkg::REG_TURNS_ALPHA, 32'h1FFFF);
        end
        3: begin
          write_reg(easf_pkg::REG_MAX_ANGLE_JUMP, 32'd512);
          write_reg(easf_pkg::REG_SPIKE_RUN_LIMIT, 32'd3);
          write_reg(easf_pkg::REG_ANGLE_ALPHA, 32'd16384);
          write_reg(easf_pkg::REG_RPM_ALPHA, 32'd6554);
          write_reg(easf_pkg::REG_SPEED_STEP_LIMIT, 32'd256000);
          write_reg(easf_pkg::REG_TURNS_ALPHA, 32'd32768);
        end
        default: begin
          write_reg(easf_pkg::REG_MAX_ANGLE_JUMP, $urandom_range(0, 8192));
          write_reg(easf_pkg::REG_SPIKE_RUN_LIMIT, $urandom_range(0, 8));
          write_reg(easf_pkg::REG_ANGLE_ALPHA, $urandom_range(0, 65536));
          write_reg(easf_pkg::REG_RPM_ALPHA, $urandom_range(0, 65536));
          write_reg(easf_pkg::REG_SPEED_STEP_LIMIT, $urandom());
          write_reg(easf_pkg::REG_TURNS_ALPHA, $urandom_range(0, 65536));
        end
      endcase
      // mostly a rotating shaft with noise, spikes, speed/turn updates and unused actions
      base = $urandom();
      n = 95;
      for (k = 0; k < n; k++) begin
        sel = $urandom_range(0, 19);
        if (sel < 10) begin
          base = base + 14'($signed($urandom_range(0, 1200)) - 400);
          w = make_word(easf_pkg::ACT_SAMPLE, {base, 2'($urandom())}, 24'($urandom()));
        end else if (sel < 12) begin
          w = make_word(easf_pkg::ACT_SAMPLE, 16'($urandom()), 24'($urandom()));
        end else if (sel < 15) begin
          w = make_word(easf_pkg::ACT_SPEED, 16'($urandom()),
                        ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                                    : 24'($urandom_range(0, 2000)));
        end else if (sel < 19) begin
          w = make_word(easf_pkg::ACT_TURNS, 16'($urandom()), 24'($urandom()));
        end else begin
          w = make_word(ACT_NONE, 16'($urandom()), 24'($urandom()));
        end
        send_word(w, 1'b0, none, 1'b1);
      end
      drain();
    end

    $display("sent %0d words (%0d speed updates), checked %0d results over 8 settings",
             words_sent, speed_words, words_checked);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
